### rtl/fbclip_pkg.sv
// ----------------------------------------------------------------------------
// fbclip_pkg
// Shared widths, codes and bus types of the draw-command clipper.
// ----------------------------------------------------------------------------
package fbclip_pkg;

    // field widths
    localparam int ACT_W    = 3;
    localparam int COORD_W  = 16;
    localparam int SIZE_W   = 16;
    localparam int COLOR_W  = 32;
    localparam int SCR_W    = 13;
    localparam int STRIDE_W = 14;
    localparam int IDX_W    = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // screen size limits applied on register write
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // stream payload widths
    localparam int IN_DATA_W  = 4 * COORD_W + 2 * SIZE_W + COLOR_W;
    localparam int OUT_RAW_W  = IDX_W + STRIDE_W + SCR_W + COLOR_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // command codes
    typedef enum logic [ACT_W-1:0] {
        ACT_PIXEL   = 3'd0,
        ACT_HLINE   = 3'd1,
        ACT_VLINE   = 3'd2,
        ACT_OUTLINE = 3'd3,
        ACT_FILL    = 3'd4,
        ACT_CLEAR   = 3'd5
    } t_action;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED    = 2'd0,
        REG_SCR_WIDTH  = 2'd1,
        REG_SCR_HEIGHT = 2'd2,
        REG_STRIDE     = 2'd3
    } t_cfg_reg;

    // register file contents
    typedef struct packed {
        logic                enabled;
        logic [SCR_W-1:0]    scr_width;
        logic [SCR_W-1:0]    scr_height;
        logic [STRIDE_W-1:0] stride;
    } t_cfg;

    // clipped span before address generation
    typedef struct packed {
        logic                drawn;
        logic                last;
        logic [SCR_W-1:0]    x0;
        logic [SCR_W-1:0]    y0;
        logic [STRIDE_W-1:0] width;
        logic [SCR_W-1:0]    rows;
        logic [COLOR_W-1:0]  color;
    } t_span;

endpackage

### rtl/fbclip_cfg.sv
// ----------------------------------------------------------------------------
// fbclip_cfg
// Configuration registers with screen size saturation.
// ----------------------------------------------------------------------------
module fbclip_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fbclip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbclip_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output fbclip_pkg::t_cfg                  o_cfg
);
    import fbclip_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register write, sizes saturated to the screen limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ENABLED: begin
                    r_cfg.enabled <= i_cfg_data[0];
                end
                REG_SCR_WIDTH: begin
                    if (int'(i_cfg_data[SCR_W-1:0]) > MAX_WIDTH)
                        r_cfg.scr_width <= SCR_W'(MAX_WIDTH);
                    else
                        r_cfg.scr_width <= i_cfg_data[SCR_W-1:0];
                end
                REG_SCR_HEIGHT: begin
                    if (int'(i_cfg_data[SCR_W-1:0]) > MAX_HEIGHT)
                        r_cfg.scr_height <= SCR_W'(MAX_HEIGHT);
                    else
                        r_cfg.scr_height <= i_cfg_data[SCR_W-1:0];
                end
                REG_STRIDE: begin
                    r_cfg.stride <= i_cfg_data[STRIDE_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

endmodule

### rtl/fbclip_clip.sv
// ----------------------------------------------------------------------------
// fbclip_clip
// Command register, outline span sequencer and screen clipping stage.
// ----------------------------------------------------------------------------
module fbclip_clip (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fbclip_pkg::t_cfg                   i_cfg,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [fbclip_pkg::ACT_W-1:0]       i_action,
    input  logic [fbclip_pkg::IN_DATA_W-1:0]   i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output fbclip_pkg::t_span                  o_span
);
    import fbclip_pkg::*;

    // signed work width: holds a corner plus a full rectangle size
    localparam int CW = COORD_W + 3;
    localparam logic signed [CW-1:0] ONE  = CW'(1);
    localparam logic signed [CW-1:0] ZERO = '0;

    // command register
    logic                r_in_v;
    logic [ACT_W-1:0]    r_action;
    logic [COORD_W-1:0]  r_pos_x, r_pos_y, r_end_x, r_end_y;
    logic [SIZE_W-1:0]   r_rect_w, r_rect_h;
    logic [COLOR_W-1:0]  r_color;
    logic [1:0]          r_idx;

    // clip stage register
    logic  r_clip_v;
    t_span r_clip;
    t_span n_clip;

    logic clip_rdy, in_adv, last_span, take;

    logic signed [CW-1:0] px, py, ex, ey, rw, rh, xr, yb;
    logic signed [CW-1:0] bx0, by0, bx1, by1;
    logic signed [CW-1:0] wmax, hmax, cx0, cy0, cx1, cy1, dx, dy;
    logic rect_nz, box_ok, box_hit, is_clear;

    // handshake
    assign last_span = (r_action != ACT_OUTLINE) || (r_idx == 2'd3);
    assign clip_rdy  = !r_clip_v || i_ready;
    assign in_adv    = r_in_v && clip_rdy;
    assign o_ready   = !r_in_v || (in_adv && last_span);
    assign take      = i_valid && o_ready;
    assign o_valid   = r_clip_v;
    assign o_span    = r_clip;

    // command register and span counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_idx  <= 2'd0;
        end else if (take) begin
            r_in_v <= 1'b1;
            r_idx  <= 2'd0;
        end else if (in_adv && last_span) begin
            r_in_v <= 1'b0;
        end else if (in_adv) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_action <= i_action;
            r_pos_x  <= i_data[0*COORD_W +: COORD_W];
            r_pos_y  <= i_data[1*COORD_W +: COORD_W];
            r_end_x  <= i_data[2*COORD_W +: COORD_W];
            r_end_y  <= i_data[3*COORD_W +: COORD_W];
            r_rect_w <= i_data[4*COORD_W +: SIZE_W];
            r_rect_h <= i_data[4*COORD_W+SIZE_W +: SIZE_W];
            r_color  <= i_data[4*COORD_W+2*SIZE_W +: COLOR_W];
        end
    end

    // operands extended to the work width
    assign px = {{(CW-COORD_W){r_pos_x[COORD_W-1]}}, r_pos_x};
    assign py = {{(CW-COORD_W){r_pos_y[COORD_W-1]}}, r_pos_y};
    assign ex = {{(CW-COORD_W){r_end_x[COORD_W-1]}}, r_end_x};
    assign ey = {{(CW-COORD_W){r_end_y[COORD_W-1]}}, r_end_y};
    assign rw = {{(CW-SIZE_W){1'b0}}, r_rect_w};
    assign rh = {{(CW-SIZE_W){1'b0}}, r_rect_h};
    assign xr = px + rw - ONE;
    assign yb = py + rh - ONE;
    assign rect_nz = (r_rect_w != '0) && (r_rect_h != '0);

    // inclusive box of the current span, endpoints ordered
    always_comb begin
        bx0      = px;
        by0      = py;
        bx1      = px;
        by1      = py;
        box_ok   = 1'b1;
        is_clear = 1'b0;
        unique case (r_action)
            ACT_PIXEL: begin
                box_ok = 1'b1;
            end
            ACT_HLINE: begin
                if (px > ex) begin
                    bx0 = ex;
                    bx1 = px;
                end else begin
                    bx1 = ex;
                end
            end
            ACT_VLINE: begin
                if (py > ey) begin
                    by0 = ey;
                    by1 = py;
                end else begin
                    by1 = ey;
                end
            end
            ACT_OUTLINE: begin
                box_ok = rect_nz;
                // sides in the order top, bottom, left, right
                case (r_idx)
                    2'd0: begin
                        bx1 = xr;
                    end
                    2'd1: begin
                        bx1 = xr;
                        by0 = yb;
                        by1 = yb;
                    end
                    2'd2: begin
                        by1 = yb;
                    end
                    default: begin
                        bx0 = xr;
                        bx1 = xr;
                        by1 = yb;
                    end
                endcase
            end
            ACT_FILL: begin
                bx1    = xr;
                by1    = yb;
                box_ok = rect_nz;
            end
            ACT_CLEAR: begin
                is_clear = 1'b1;
            end
            default: begin
                box_ok = 1'b0;
            end
        endcase
    end

    // clamp against the screen
    assign wmax = {{(CW-SCR_W){1'b0}}, i_cfg.scr_width} - ONE;
    assign hmax = {{(CW-SCR_W){1'b0}}, i_cfg.scr_height} - ONE;
    assign cx0  = (bx0 < ZERO) ? ZERO : bx0;
    assign cy0  = (by0 < ZERO) ? ZERO : by0;
    assign cx1  = (bx1 > wmax) ? wmax : bx1;
    assign cy1  = (by1 > hmax) ? hmax : by1;
    assign dx   = cx1 - cx0;
    assign dy   = cy1 - cy0;
    assign box_hit = (cx0 <= cx1) && (cy0 <= cy1);

    // span fields for the next stage
    always_comb begin
        n_clip.last  = last_span;
        n_clip.color = r_color;
        if (is_clear) begin
            n_clip.drawn = i_cfg.enabled && (i_cfg.stride != '0)
                           && (i_cfg.scr_height != '0);
            n_clip.x0    = '0;
            n_clip.y0    = '0;
            n_clip.width = i_cfg.stride;
            n_clip.rows  = i_cfg.scr_height;
        end else begin
            n_clip.drawn = i_cfg.enabled && box_ok && box_hit;
            n_clip.x0    = cx0[SCR_W-1:0];
            n_clip.y0    = cy0[SCR_W-1:0];
            n_clip.width = dx[STRIDE_W-1:0] + STRIDE_W'(1);
            n_clip.rows  = dy[SCR_W-1:0] + SCR_W'(1);
        end
    end

    // clip stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_v <= 1'b0;
        end else if (clip_rdy) begin
            r_clip_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clip_rdy) begin
            r_clip <= n_clip;
        end
    end

endmodule

### rtl/fbclip_addr.sv
// ----------------------------------------------------------------------------
// fbclip_addr
// Start index generation (row times stride plus column) and result register.
// ----------------------------------------------------------------------------
module fbclip_addr (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fbclip_pkg::t_cfg                   i_cfg,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  fbclip_pkg::t_span                  i_span,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [fbclip_pkg::OUT_DATA_W-1:0]  o_data,
    output logic                               o_drawn,
    output logic                               o_last
);
    import fbclip_pkg::*;

    localparam int PROD_W = SCR_W + STRIDE_W;

    logic                r_v;
    logic [IDX_W-1:0]    r_start;
    logic [STRIDE_W-1:0] r_width;
    logic [SCR_W-1:0]    r_rows;
    logic [COLOR_W-1:0]  r_color;
    logic                r_drawn;
    logic                r_last;

    logic [PROD_W-1:0]   prod;
    logic [IDX_W-1:0]    n_start;

    assign o_ready = !r_v || i_ready;

    // pixel index, wrapped to the index width
    assign prod    = PROD_W'(i_span.y0) * PROD_W'(i_cfg.stride);
    assign n_start = IDX_W'(prod + PROD_W'(i_span.x0));

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // a span that is not drawn carries zeros
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_drawn <= i_span.drawn;
            r_last  <= i_span.last;
            r_start <= i_span.drawn ? n_start      : '0;
            r_width <= i_span.drawn ? i_span.width : '0;
            r_rows  <= i_span.drawn ? i_span.rows  : '0;
            r_color <= i_span.drawn ? i_span.color : '0;
        end
    end

    assign o_valid = r_v;
    assign o_drawn = r_drawn;
    assign o_last  = r_last;
    assign o_data  = {{(OUT_DATA_W-OUT_RAW_W){1'b0}}, r_color, r_rows, r_width, r_start};

endmodule

### rtl/framebuffer_draw_clipper_top.sv
// ----------------------------------------------------------------------------
// framebuffer_draw_clipper_top
// Draw-command clipper: turns pixel, line, rectangle and clear commands into
// clipped fill spans (start index, width, rows, color).
// ----------------------------------------------------------------------------
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready   tuser: action, tdata: command
//  m_axis   out  m_axis_tvalid / m_axis_tready   tuser: drawn, tlast: last, tdata: span
//  cfg      in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One command beat per cycle when the span stream does not stall; an outline
// holds the command register for four spans. Each command beat passes the
// command register, clip register and result register (the stride multiply).
// s_axis_tready is high when the command register is empty or its last span
// moves on; an outline blocks new commands during its first three spans.
// Reset is synchronous, active low, and clears the valid flags and the
// configuration registers to 0.
// ----------------------------------------------------------------------------
module framebuffer_draw_clipper_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // action
    input  logic [fbclip_pkg::ACT_W-1:0]       s_axis_tuser,
    // pos_x, pos_y, end_x, end_y, rect_width, rect_height, color
    input  logic [fbclip_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // span stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // drawn
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    // start_index, span_width, span_rows, span_color, zero pad
    output logic [fbclip_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fbclip_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbclip_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fbclip_pkg::*;

    t_cfg  cfg;
    t_span span;
    logic  span_valid;
    logic  span_ready;

    // register file
    fbclip_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // command register, sequencer and clipping
    fbclip_clip u_clip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_valid  (span_valid),
        .i_ready  (span_ready),
        .o_span   (span)
    );

    // index generation and result register
    fbclip_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (span_valid),
        .o_ready (span_ready),
        .i_span  (span),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_drawn (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the draw-command clipper span by span against a behavioral model of
// clipping and index generation. Directed commands cover screen edges, line
// swaps, outline corner cases, clear and reserved actions; random phases
// change the screen registers and push commands with random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import fbclip_pkg::*;

    // reserved action codes, outside the package enum
    localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd7;

    // one draw command as carried by the command stream
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [SIZE_W-1:0]  rect_width;
        logic [SIZE_W-1:0]  rect_height;
        logic [COLOR_W-1:0] color;
    } draw_cmd_t;

    // one span beat as seen on the span stream
    typedef struct packed {
        logic [IDX_W-1:0]    start_index;
        logic [STRIDE_W-1:0] span_width;
        logic [SCR_W-1:0]    span_rows;
        logic [COLOR_W-1:0]  span_color;
        logic                drawn;
        logic                last;
    } span_beat_t;

    // span predictor and in-order checker
    class span_scoreboard;
        bit         enabled;
        longint     scr_w;
        longint     scr_h;
        longint     stride;
        span_beat_t pending[$];
        int         errors;

        function new();
            enabled = 0;
            scr_w   = 0;
            scr_h   = 0;
            stride  = 0;
            errors  = 0;
        endfunction

        // register write, with screen sizes saturated
        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLED:    enabled = data[0];
                REG_SCR_WIDTH:  scr_w = (data[SCR_W-1:0] > MAX_WIDTH) ? MAX_WIDTH
                                                                      : data[SCR_W-1:0];
                REG_SCR_HEIGHT: scr_h = (data[SCR_W-1:0] > MAX_HEIGHT) ? MAX_HEIGHT
                                                                       : data[SCR_W-1:0];
                REG_STRIDE:     stride = data;
                default: ;
            endcase
        endfunction

        function span_beat_t blank_span(bit last);
            span_beat_t s;
            s = '0;
            s.last = last;
            return s;
        endfunction

        // order both axes, intersect with the screen, form the span
        function span_beat_t clip_area(longint xa, longint ya, longint xb, longint yb,
                                       logic [COLOR_W-1:0] color, bit last);
            span_beat_t s;
            longint     t;
            s = blank_span(last);
            if (xa > xb) begin
                t = xa; xa = xb; xb = t;
            end
            if (ya > yb) begin
                t = ya; ya = yb; yb = t;
            end
            if (xa < 0) xa = 0;
            if (ya < 0) ya = 0;
            if (xb > scr_w - 1) xb = scr_w - 1;
            if (yb > scr_h - 1) yb = scr_h - 1;
            if (!enabled || xa > xb || ya > yb) return s;
            s.drawn       = 1'b1;
            s.start_index = IDX_W'(ya * stride + xa);
            s.span_width  = STRIDE_W'(xb - xa + 1);
            s.span_rows   = SCR_W'(yb - ya + 1);
            s.span_color  = color;
            return s;
        endfunction

        // expected spans of one accepted command
        function void note_command(draw_cmd_t c);
            longint     px;
            longint     py;
            longint     ex;
            longint     ey;
            longint     xr;
            longint     yb;
            bit         empty;
            span_beat_t s;
            px = longint'($signed(c.pos_x));
            py = longint'($signed(c.pos_y));
            ex = longint'($signed(c.end_x));
            ey = longint'($signed(c.end_y));
            xr = px + longint'(c.rect_width) - 1;
            yb = py + longint'(c.rect_height) - 1;
            empty = (c.rect_width == 0) || (c.rect_height == 0);
            case (c.action)
                ACT_PIXEL: pending.push_back(clip_area(px, py, px, py, c.color, 1));
                ACT_HLINE: pending.push_back(clip_area(px, py, ex, py, c.color, 1));
                ACT_VLINE: pending.push_back(clip_area(px, py, px, ey, c.color, 1));
                ACT_OUTLINE: begin
                    // top, bottom, left, right
                    if (empty) begin
                        repeat (3) pending.push_back(blank_span(0));
                        pending.push_back(blank_span(1));
                    end else begin
                        pending.push_back(clip_area(px, py, xr, py, c.color, 0));
                        pending.push_back(clip_area(px, yb, xr, yb, c.color, 0));
                        pending.push_back(clip_area(px, py, px, yb, c.color, 0));
                        pending.push_back(clip_area(xr, py, xr, yb, c.color, 1));
                    end
                end
                ACT_FILL: begin
                    if (empty) pending.push_back(blank_span(1));
                    else pending.push_back(clip_area(px, py, xr, yb, c.color, 1));
                end
                ACT_CLEAR: begin
                    s = blank_span(1);
                    if (enabled && stride != 0 && scr_h != 0) begin
                        s.drawn      = 1'b1;
                        s.span_width = STRIDE_W'(stride);
                        s.span_rows  = SCR_W'(scr_h);
                        s.span_color = c.color;
                    end
                    pending.push_back(s);
                end
                default: pending.push_back(blank_span(1));
            endcase
        endfunction

        // compare one span beat with the oldest expected span
        function void check_span(span_beat_t got);
            span_beat_t exp_s;
            if (pending.size() == 0) begin
                $error("span beat with no span expected");
                errors++;
                return;
            end
            exp_s = pending.pop_front();
            if (got.start_index !== exp_s.start_index) begin
                $error("start_index expected %0d got %0d", exp_s.start_index, got.start_index);
                errors++;
            end
            if (got.span_width !== exp_s.span_width) begin
                $error("span_width expected %0d got %0d", exp_s.span_width, got.span_width);
                errors++;
            end
            if (got.span_rows !== exp_s.span_rows) begin
                $error("span_rows expected %0d got %0d", exp_s.span_rows, got.span_rows);
                errors++;
            end
            if (got.span_color !== exp_s.span_color) begin
                $error("span_color expected %h got %h", exp_s.span_color, got.span_color);
                errors++;
            end
            if (got.drawn !== exp_s.drawn) begin
                $error("drawn expected %0d got %0d", exp_s.drawn, got.drawn);
                errors++;
            end
            if (got.last !== exp_s.last) begin
                $error("last expected %0d got %0d", exp_s.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [ACT_W-1:0]      s_axis_tuser = '0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    span_scoreboard board;
    bit             steady_run = 1'b0;

    framebuffer_draw_clipper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // span sink back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= steady_run || ($urandom_range(99) >= 27);
    end

    // span beat monitor
    always @(posedge i_clk) begin : span_monitor
        span_beat_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.start_index = m_axis_tdata[IDX_W-1:0];
            got.span_width  = m_axis_tdata[IDX_W +: STRIDE_W];
            got.span_rows   = m_axis_tdata[IDX_W+STRIDE_W +: SCR_W];
            got.span_color  = m_axis_tdata[IDX_W+STRIDE_W+SCR_W +: COLOR_W];
            got.drawn       = m_axis_tuser;
            got.last        = m_axis_tlast;
            board.check_span(got);
        end
    end

    // register write; valid stays up for a following write
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] en, w, h, stride);
        write_reg(REG_ENABLED, en);
        write_reg(REG_SCR_WIDTH, w);
        write_reg(REG_SCR_HEIGHT, h);
        write_reg(REG_STRIDE, stride);
        i_cfg_valid <= 1'b0;
    endtask

    // one command beat, after a random gap
    task automatic send_command(input draw_cmd_t c);
        while (!steady_run && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.action;
        s_axis_tdata  <= {c.color, c.rect_height, c.rect_width,
                          c.end_y, c.end_x, c.pos_y, c.pos_x};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_command(c);
    endtask

    // hold off commands until every expected span has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic draw_cmd_t make_cmd(logic [ACT_W-1:0] action, longint px, longint py,
                                           longint ex, longint ey, longint rw, longint rh,
                                           logic [COLOR_W-1:0] color);
        draw_cmd_t c;
        c.action      = action;
        c.pos_x       = COORD_W'(px);
        c.pos_y       = COORD_W'(py);
        c.end_x       = COORD_W'(ex);
        c.end_y       = COORD_W'(ey);
        c.rect_width  = SIZE_W'(rw);
        c.rect_height = SIZE_W'(rh);
        c.color       = color;
        return c;
    endfunction

    // mostly near the screen, sometimes anywhere or at the extremes
    function automatic logic [COORD_W-1:0] rand_coord(longint reach);
        case ($urandom_range(19))
            0, 1:    return COORD_W'($urandom);
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'hFFFF;
            default: return COORD_W'(longint'($urandom_range(reach + 40)) - 20);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size(longint reach);
        case ($urandom_range(19))
            0:       return '0;
            1:       return SIZE_W'($urandom);
            2:       return 16'd1;
            3:       return 16'hFFFF;
            default: return SIZE_W'($urandom_range(1, reach / 2 + 2));
        endcase
    endfunction

    function automatic draw_cmd_t random_command(longint reach_x, longint reach_y);
        draw_cmd_t c;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 3) c.action = pick[0] ? ACT_RSVD_A : ACT_RSVD_B;
        else c.action = ACT_W'($urandom_range(ACT_CLEAR));
        c.pos_x       = rand_coord(reach_x);
        c.pos_y       = rand_coord(reach_y);
        c.end_x       = rand_coord(reach_x);
        c.end_y       = rand_coord(reach_y);
        c.rect_width  = rand_size(reach_x);
        c.rect_height = rand_size(reach_y);
        c.color       = $urandom;
        return c;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_extent();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 14'd1;
            2:       return CFG_DATA_W'($urandom_range(2, 64));
            3:       return CFG_DATA_W'($urandom_range(65, 4095));
            4:       return CFG_DATA_W'(MAX_WIDTH);
            5:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(16, 800));
        endcase
    endfunction

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] en;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        logic [CFG_DATA_W-1:0] stride;
        longint                weff;
        en   = {13'($urandom), 1'($urandom_range(9) != 0)};
        w    = pick_extent();
        h    = pick_extent();
        weff = (w[SCR_W-1:0] > MAX_WIDTH) ? MAX_WIDTH : w[SCR_W-1:0];
        case ($urandom_range(5))
            0:       stride = '0;
            1:       stride = 14'h3FFF;
            2:       stride = CFG_DATA_W'($urandom);
            3:       stride = CFG_DATA_W'(weff);
            default: stride = CFG_DATA_W'(weff + $urandom_range(64));
        endcase
        apply_settings(en, w, h, stride);
    endtask

    // main sequence
    initial begin : stimulus
        longint reach_x;
        longint reach_y;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers still at reset: everything blank
        send_command(make_cmd(ACT_PIXEL, 5, 5, 0, 0, 0, 0, $urandom));
        send_command(make_cmd(ACT_OUTLINE, 1, 1, 0, 0, 4, 4, $urandom));
        send_command(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, $urandom));
        send_command(make_cmd(ACT_FILL, 0, 0, 0, 0, 8, 8, $urandom));
        drain();

        // directed commands on a 640x480 screen
        apply_settings(14'd1, 14'd640, 14'd480, 14'd640);
        send_command(make_cmd(ACT_PIXEL, 0, 0, 0, 0, 0, 0, 32'h0));
        send_command(make_cmd(ACT_PIXEL, 639, 479, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_command(make_cmd(ACT_PIXEL, 640, 0, 0, 0, 0, 0, $urandom));
        send_command(make_cmd(ACT_PIXEL, -1, 5, 0, 0, 0, 0, $urandom));
        send_command(make_cmd(ACT_PIXEL, -32768, 32767, 0, 0, 0, 0, $urandom));
        // reversed endpoints, clipped on both sides
        send_command(make_cmd(ACT_HLINE, 700, 3, -10, 0, 0, 0, $urandom));
        send_command(make_cmd(ACT_HLINE, 0, 480, 100, 0, 0, 0, $urandom));
        send_command(make_cmd(ACT_VLINE, 10, 500, 0, -5, 0, 0, $urandom));
        send_command(make_cmd(ACT_VLINE, -1, 0, 0, 100, 0, 0, $urandom));
        // outline: normal, one pixel wide, one pixel high, zero size, partly off
        send_command(make_cmd(ACT_OUTLINE, 10, 20, 0, 0, 30, 40, $urandom));
        send_command(make_cmd(ACT_OUTLINE, 100, 100, 0, 0, 1, 5, $urandom));
        send_command(make_cmd(ACT_OUTLINE, 100, 100, 0, 0, 5, 1, $urandom));
        send_command(make_cmd(ACT_OUTLINE, 5, 5, 0, 0, 0, 7, $urandom));
        send_command(make_cmd(ACT_OUTLINE, -5, 470, 0, 0, 700, 20, $urandom));
        // fill: normal, zero size, wholly off left, wholly off top, whole screen
        send_command(make_cmd(ACT_FILL, 50, 60, 0, 0, 10, 10, $urandom));
        send_command(make_cmd(ACT_FILL, 50, 60, 0, 0, 0, 10, $urandom));
        send_command(make_cmd(ACT_FILL, -100, 10, 0, 0, 50, 10, $urandom));
        send_command(make_cmd(ACT_FILL, 10, -100, 0, 0, 10, 50, $urandom));
        send_command(make_cmd(ACT_FILL, -32768, -32768, 0, 0, 65535, 65535, $urandom));
        send_command(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, $urandom));
        send_command(make_cmd(ACT_RSVD_A, 1, 1, 1, 1, 1, 1, $urandom));
        send_command(make_cmd(ACT_RSVD_B, 1, 1, 1, 1, 1, 1, $urandom));
        drain();

        // random phases: largest screen, empty screen, then random settings
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       apply_settings(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
                1:       apply_settings(14'd1, 14'd0, 14'd0, 14'd0);
                default: random_settings();
            endcase
            steady_run = (phase == 3);
            reach_x = (board.scr_w > 16) ? board.scr_w : 16;
            reach_y = (board.scr_h > 16) ? board.scr_h : 16;
            repeat (70) send_command(random_command(reach_x, reach_y));
            drain();
        end
        steady_run = 1'b0;

        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
